### rtl/core/bdq_pkg.sv
// Package with the shared constants, types and helper functions of the deque.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;
    localparam int PTR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int OP_W       = 2;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int RD_W       = 32;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT = 2'd0,
        OP_ADD_BACK  = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADIDX   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [PTR_W-1:0]      raddr;
    } ram_req_t;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] logical);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(logical);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] head);
        logic [PTR_W-1:0] res;
        if (head == '0)
        begin
            res = PTR_W'(CAPACITY - 1);
        end
        else
        begin
            res = head - PTR_W'(1);
        end
        return res;
    endfunction

endpackage

### rtl/core/bounded_deque_with_remove.sv
// Top level of the bounded deque with remove by value and read by index.
`timescale 1ns / 1ps

// An item is taken when start is high while busy is low, and its single result
// appears on read_value, status and count for one cycle with done high; the
// receiver cannot stall it. An add shows its result in the next cycle; a valid
// read passes through the registered store read and then the result registers.
// A remove scans the entries through the single read port of the store one per
// cycle and then shifts every later entry forward one per cycle. The entry
// store needs no clearing after reset.
module bounded_deque_with_remove (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bdq_pkg::OP_W-1:0]          op,
    input  logic signed [31:0]                value,
    input  logic [bdq_pkg::POS_W-1:0]         position,
    output logic                              done,
    output logic signed [31:0]                read_value,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic [bdq_pkg::CNT_W-1:0]         count
);
    import bdq_pkg::*;

    ram_req_t              ram_req;
    logic [VALUE_BITS-1:0] ram_rdata;

    bdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .position   (position),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .count      (count),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    bdq_store u_store (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

### rtl/core/bdq_store.sv
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module bdq_store (
    input  logic                              clk,
    input  bdq_pkg::ram_req_t                 req,
    output logic [bdq_pkg::VALUE_BITS-1:0]    rdata
);
    import bdq_pkg::*;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bdq_ctrl.sv
// Sequencer that tracks head and count and drives adds, reads, scans and shifts.
`timescale 1ns / 1ps

module bdq_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bdq_pkg::OP_W-1:0]          op,
    input  logic signed [31:0]                value,
    input  logic [bdq_pkg::POS_W-1:0]         position,
    output logic                              done,
    output logic signed [31:0]                read_value,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic [bdq_pkg::CNT_W-1:0]         count,
    output bdq_pkg::ram_req_t                 ram_req,
    input  logic [bdq_pkg::VALUE_BITS-1:0]    ram_rdata
);
    import bdq_pkg::*;

    state_t                state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  wr_valid_reg, wr_valid_next;
    logic [CNT_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                  done_reg, done_next;
    logic [RD_W-1:0]       rd_reg, rd_next;
    status_t               status_reg, status_next;
    logic [CNT_W-1:0]      cnt_out_reg, cnt_out_next;

    op_t                   op_in;
    logic                  accept;
    logic                  full;
    logic                  read_bad;
    logic                  match;
    logic                  scan_last;

    assign op_in     = op_t'(op);
    assign accept    = start && (state_reg == S_IDLE);
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign read_bad  = (CMP_W'(position) >= CMP_W'(count_reg));
    assign match     = (ram_rdata == value_reg);
    assign scan_last = ((cmp_idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op_in)
                        OP_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            if ((count_reg != '0) && !read_bad)
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (cmp_valid_reg)
                begin
                    if (match)
                    begin
                        state_next = S_SHIFT;
                    end
                    else if (scan_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        wr_valid_next  = 1'b0;
        wr_idx_next    = wr_idx_reg;
        done_next      = 1'b0;
        rd_next        = '0;
        status_next    = ST_OK;
        cnt_out_next   = count_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = slot_of(head_reg, wr_idx_reg);
        ram_req.wdata  = ram_rdata;
        ram_req.raddr  = slot_of(head_reg, idx_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = VALUE_BITS'(value);
                    case (op_in)
                        OP_ADD_FRONT:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                head_next     = prev_slot(head_reg);
                                count_next    = count_reg + CNT_W'(1);
                                cnt_out_next  = count_next;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = prev_slot(head_reg);
                                ram_req.wdata = VALUE_BITS'(value);
                            end
                        end
                        OP_ADD_BACK:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next    = count_reg + CNT_W'(1);
                                cnt_out_next  = count_next;
                                ram_req.we    = 1'b1;
                                ram_req.waddr = slot_of(head_reg, count_reg);
                                ram_req.wdata = VALUE_BITS'(value);
                            end
                        end
                        OP_REMOVE:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOTFOUND;
                            end
                        end
                        OP_READ:
                        begin
                            ram_req.raddr = slot_of(head_reg, CNT_W'(position));
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (read_bad)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADIDX;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                done_next = 1'b1;
                rd_next   = RD_W'(ram_rdata);
            end
            S_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                    idx_next       = idx_reg + CNT_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (match)
                    begin
                        cmp_valid_next = 1'b0;
                        idx_next       = cmp_idx_reg + CNT_W'(1);
                    end
                    else if (scan_last)
                    begin
                        cmp_valid_next = 1'b0;
                        done_next      = 1'b1;
                        status_next    = ST_NOTFOUND;
                    end
                end
            end
            S_SHIFT:
            begin
                ram_req.we = wr_valid_reg;
                if (idx_reg < count_reg)
                begin
                    wr_valid_next = 1'b1;
                    wr_idx_next   = idx_reg - CNT_W'(1);
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    cnt_out_next = count_next;
                    done_next    = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_valid_reg  <= wr_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rd_reg;
    assign status     = status_reg;
    assign count      = cnt_out_reg;

endmodule
